>>> hw/rtl/bkbc_pkg.sv
// shared types and constants of the bracket and keyword balance checker
package bkbc_pkg;

  // kind of opener held on the stack
  localparam logic [1:0] KIND_PAREN  = 2'd0;
  localparam logic [1:0] KIND_SQUARE = 2'd1;
  localparam logic [1:0] KIND_CURLY  = 2'd2;
  localparam logic [1:0] KIND_BEGIN  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_PLAIN      = 3'd0;
  localparam logic [2:0] ST_OPENED     = 3'd1;
  localparam logic [2:0] ST_MATCHED    = 3'd2;
  localparam logic [2:0] ST_MISMATCH   = 3'd3;
  localparam logic [2:0] ST_UNDERFLOW  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW   = 3'd5;
  localparam logic [2:0] ST_BALANCED   = 3'd6;
  localparam logic [2:0] ST_UNBALANCED = 3'd7;

  // expected closer code when the stack is empty
  localparam logic [2:0] CLOSER_NONE = 3'd0;

  // field widths of the result
  localparam int unsigned StatusW = 3;
  localparam int unsigned CloserW = 3;
  localparam int unsigned DepthW  = 7;

  // source characters that matter
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LSQ    = 8'h5B;
  localparam logic [7:0] CH_RSQ    = 8'h5D;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_LO_G   = 8'h67;
  localparam logic [7:0] CH_LO_I   = 8'h69;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_D   = 8'h64;
  localparam logic [7:0] CH_UP_B   = 8'h42;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_UP_G   = 8'h47;
  localparam logic [7:0] CH_UP_I   = 8'h49;
  localparam logic [7:0] CH_UP_N   = 8'h4E;
  localparam logic [7:0] CH_UP_D   = 8'h44;

  // operation the back end carries out
  typedef enum logic [1:0] {
    OP_PLAIN = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2,
    OP_EOP   = 2'd3
  } op_e;

  // classified request passed through the queue
  typedef struct packed {
    op_e        op;
    logic [1:0] kind;
  } op_t;

endpackage

>>> hw/rtl/bkbc_front.sv
// front end: accepts characters, tracks recent bytes and classifies tokens
module bkbc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      in_char_i,
  input  logic            in_eop_i,
  output logic            in_ready_o,
  input  logic            q_full_i,
  output logic            q_push_o,
  output bkbc_pkg::op_t   q_op_o
);
  import bkbc_pkg::*;

  logic [31:0] recent_q, recent_d;
  logic [2:0]  rcount_q, rcount_d;
  logic        fire;
  logic        is_begin, is_end;
  op_t         op;

  assign in_ready_o = ~q_full_i;
  assign fire       = in_valid_i & ~q_full_i;
  assign q_push_o   = fire;
  assign q_op_o     = op;

  // keyword suffix match against the recent bytes, newest in the low byte
  always_comb begin
    is_begin = (rcount_q >= 3'd4) &&
               (((in_char_i == CH_LO_N) && (recent_q[7:0] == CH_LO_I) &&
                 (recent_q[15:8] == CH_LO_G) && (recent_q[23:16] == CH_LO_E) &&
                 (recent_q[31:24] == CH_LO_B)) ||
                ((in_char_i == CH_UP_N) && (recent_q[7:0] == CH_UP_I) &&
                 (recent_q[15:8] == CH_UP_G) && (recent_q[23:16] == CH_UP_E) &&
                 (recent_q[31:24] == CH_UP_B)));
    is_end   = (rcount_q >= 3'd2) &&
               (((in_char_i == CH_LO_D) && (recent_q[7:0] == CH_LO_N) &&
                 (recent_q[15:8] == CH_LO_E)) ||
                ((in_char_i == CH_UP_D) && (recent_q[7:0] == CH_UP_N) &&
                 (recent_q[15:8] == CH_UP_E)));
  end

  // classify the request
  always_comb begin
    op.op   = OP_PLAIN;
    op.kind = KIND_PAREN;
    priority if (in_eop_i) begin
      op.op = OP_EOP;
    end else if (in_char_i == CH_LPAREN) begin
      op.op = OP_OPEN;   op.kind = KIND_PAREN;
    end else if (in_char_i == CH_LSQ) begin
      op.op = OP_OPEN;   op.kind = KIND_SQUARE;
    end else if (in_char_i == CH_LCURLY) begin
      op.op = OP_OPEN;   op.kind = KIND_CURLY;
    end else if (is_begin) begin
      op.op = OP_OPEN;   op.kind = KIND_BEGIN;
    end else if (in_char_i == CH_RPAREN) begin
      op.op = OP_CLOSE;  op.kind = KIND_PAREN;
    end else if (in_char_i == CH_RSQ) begin
      op.op = OP_CLOSE;  op.kind = KIND_SQUARE;
    end else if (in_char_i == CH_RCURLY) begin
      op.op = OP_CLOSE;  op.kind = KIND_CURLY;
    end else if (is_end) begin
      op.op = OP_CLOSE;  op.kind = KIND_BEGIN;
    end else begin
      op.op = OP_PLAIN;
    end
  end

  // recent byte history: tokens and end of program clear it
  always_comb begin
    recent_d = recent_q;
    rcount_d = rcount_q;
    if (fire) begin
      if (op.op == OP_PLAIN) begin
        recent_d = {recent_q[23:0], in_char_i};
        if (rcount_q < 3'd4) begin
          rcount_d = rcount_q + 3'd1;
        end
      end else begin
        recent_d = '0;
        rcount_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      rcount_q <= '0;
    end else begin
      recent_q <= recent_d;
      rcount_q <= rcount_d;
    end
  end

endmodule

>>> hw/rtl/bkbc_queue.sv
// two-entry request queue between the front end and the back end
module bkbc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bkbc_pkg::op_t   op_i,
  output logic            full_o,
  output logic            valid_o,
  output bkbc_pkg::op_t   op_o,
  input  logic            pop_i
);
  import bkbc_pkg::*;

  op_t        slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;

  assign full_o  = (fill_q == 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign op_o    = slot_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    unique case ({push_i, pop_i})
      2'b10:   fill_d = fill_q + 2'd1;
      2'b01:   fill_d = fill_q - 2'd1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

>>> hw/rtl/bkbc_back.sv
// back end: kind stack, top-of-stack register and result register
module bkbc_back #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  bkbc_pkg::op_t                  q_op_i,
  output logic                           q_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bkbc_pkg::StatusW-1:0]   out_status_o,
  output logic [bkbc_pkg::CloserW-1:0]   out_closer_o,
  output logic [bkbc_pkg::DepthW-1:0]    out_depth_o
);
  import bkbc_pkg::*;

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [CntW-1:0] Full = CntW'(STACK_DEPTH);

  // stack memory, top entry mirrored in top_q, the one below in under_q
  logic [1:0]       stack_mem [STACK_DEPTH];
  logic [1:0]       under_q;
  logic [1:0]       top_q, top_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  rd_cnt;
  logic [AddrW-1:0] rd_addr;
  logic             fire;
  logic             push;
  logic [StatusW-1:0] status;
  logic [CloserW-1:0] closer;
  logic [DepthW-1:0]  depth;
  logic             out_valid_q;
  logic [StatusW-1:0] status_q;
  logic [CloserW-1:0] closer_q;
  logic [DepthW-1:0]  depth_q;

  assign fire    = q_valid_i & (~out_valid_q | out_ready_i);
  assign q_pop_o = fire;

  // execute one request against the stack
  always_comb begin
    cnt_d  = cnt_q;
    top_d  = top_q;
    push   = 1'b0;
    status = ST_PLAIN;
    if (fire) begin
      unique case (q_op_i.op)
        OP_EOP: begin
          status = (cnt_q == '0) ? ST_BALANCED : ST_UNBALANCED;
          cnt_d  = '0;
        end
        OP_OPEN: begin
          if (cnt_q >= Full) begin
            status = ST_OVERFLOW;
          end else begin
            status = ST_OPENED;
            push   = 1'b1;
            cnt_d  = cnt_q + CntW'(1);
            top_d  = q_op_i.kind;
          end
        end
        OP_CLOSE: begin
          if (cnt_q == '0) begin
            status = ST_UNDERFLOW;
          end else if (top_q != q_op_i.kind) begin
            status = ST_MISMATCH;
          end else begin
            status = ST_MATCHED;
            cnt_d  = cnt_q - CntW'(1);
            top_d  = under_q;
          end
        end
        default: status = ST_PLAIN;
      endcase
    end
  end

  // closer and depth: end of program reports the stack before clearing
  always_comb begin
    if (q_op_i.op == OP_EOP) begin
      closer = (cnt_q == '0) ? CLOSER_NONE : {1'b0, top_q} + CloserW'(1);
      depth  = DepthW'(cnt_q);
    end else begin
      closer = (cnt_d == '0) ? CLOSER_NONE : {1'b0, top_d} + CloserW'(1);
      depth  = DepthW'(cnt_d);
    end
  end

  // prefetch the entry below the next top
  assign rd_cnt  = cnt_d - CntW'(2);
  assign rd_addr = rd_cnt[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_mem[cnt_q[AddrW-1:0]] <= q_op_i.kind;
    end
    under_q <= stack_mem[rd_addr];
    top_q   <= top_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status;
      closer_q <= closer;
      depth_q  <= depth;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;
  assign out_closer_o = closer_q;
  assign out_depth_o  = depth_q;

endmodule

>>> hw/rtl/bracket_keyword_balance_checker_unit.sv
// top level of the bracket and keyword balance checker
// throughput: one request per cycle unless the result output stalls; the top kind
// sits in a register and the stack memory read for the entry below is registered
// ahead of its use
// reset: counters, byte history and handshake state clear at once; stack
// memory is not cleared and needs no clearing pass
module bracket_keyword_balance_checker_unit #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  input  logic        s_axis_tlast,   // end_of_program
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [2:0] status, [5:3] expected_closer,
                                      // [12:6] nesting_depth, [15:13] zero
);
  import bkbc_pkg::*;

  logic      q_full, q_push, q_valid, q_pop;
  op_t       front_op, back_op;
  logic [StatusW-1:0] status;
  logic [CloserW-1:0] closer;
  logic [DepthW-1:0]  depth;

  // classify incoming characters
  bkbc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_char_i  (s_axis_tdata),
    .in_eop_i   (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_op_o     (front_op)
  );

  // decouple front and back
  bkbc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (front_op),
    .full_o  (q_full),
    .valid_o (q_valid),
    .op_o    (back_op),
    .pop_i   (q_pop)
  );

  // stack execution and result register
  bkbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_op_i       (back_op),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (status),
    .out_closer_o (closer),
    .out_depth_o  (depth)
  );

  assign m_axis_tdata = {3'b000, depth, closer, status};

endmodule

>>> tb/bkbc_balance_checker.sv
// checker for the balance checker: tracks the bracket stack and compares every result
module bkbc_balance_checker #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  import bkbc_pkg::*;

  // laid out like the result bus, status in the low bits
  typedef struct packed {
    logic [DepthW-1:0]  depth;
    logic [CloserW-1:0] closer;
    logic [StatusW-1:0] status;
  } outcome_t;

  // shadow copy of the block state
  logic [1:0]  kind_stack [STACK_DEPTH];
  int unsigned depth_cnt = 0;
  logic [31:0] history = '0;
  int unsigned history_len = 0;

  outcome_t    pending_outcomes [$];
  outcome_t    want;
  outcome_t    got;

  // closer wanted by the kind on top, none when empty
  function automatic logic [CloserW-1:0] top_closer();
    if (depth_cnt == 0) return CLOSER_NONE;
    return {1'b0, kind_stack[depth_cnt-1]} + 3'd1;
  endfunction

  // keyword ends with the current byte, earlier letters in the byte history
  function automatic bit ends_with(string word, logic [7:0] ch);
    int unsigned n;
    n = word.len();
    if (ch != word[n-1]) return 1'b0;
    if (history_len < n - 1) return 1'b0;
    for (int unsigned i = 0; i + 1 < n; i++) begin
      if (history[8*i +: 8] != word[n-2-i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [StatusW-1:0] push_kind(logic [1:0] kind);
    if (depth_cnt >= STACK_DEPTH) return ST_OVERFLOW;
    kind_stack[depth_cnt] = kind;
    depth_cnt++;
    return ST_OPENED;
  endfunction

  function automatic logic [StatusW-1:0] pop_kind(logic [1:0] kind);
    logic [CloserW-1:0] wanted;
    wanted = top_closer();
    if (wanted == CLOSER_NONE) return ST_UNDERFLOW;
    if (wanted != {1'b0, kind} + 3'd1) return ST_MISMATCH;
    depth_cnt--;
    return ST_MATCHED;
  endfunction

  // outcome of one source byte or end-of-program request
  function automatic outcome_t scan_char(logic [7:0] ch, logic eop);
    outcome_t           o;
    logic [StatusW-1:0] st;
    bit                 token;
    token = 1'b1;
    if (eop) begin
      o.status    = (depth_cnt == 0) ? ST_BALANCED : ST_UNBALANCED;
      o.closer    = top_closer();
      o.depth     = DepthW'(depth_cnt);
      depth_cnt   = 0;
      history     = '0;
      history_len = 0;
      return o;
    end
    if (ch == CH_LPAREN) st = push_kind(KIND_PAREN);
    else if (ch == CH_LSQ) st = push_kind(KIND_SQUARE);
    else if (ch == CH_LCURLY) st = push_kind(KIND_CURLY);
    else if (ends_with("begin", ch) || ends_with("BEGIN", ch)) st = push_kind(KIND_BEGIN);
    else if (ch == CH_RPAREN) st = pop_kind(KIND_PAREN);
    else if (ch == CH_RSQ) st = pop_kind(KIND_SQUARE);
    else if (ch == CH_RCURLY) st = pop_kind(KIND_CURLY);
    else if (ends_with("end", ch) || ends_with("END", ch)) st = pop_kind(KIND_BEGIN);
    else begin
      st    = ST_PLAIN;
      token = 1'b0;
    end
    // tokens wipe the byte history, plain bytes shift in
    if (token) begin
      history     = '0;
      history_len = 0;
    end else begin
      history = {history[23:0], ch};
      if (history_len < 4) history_len++;
    end
    o.status = st;
    o.closer = top_closer();
    o.depth  = DepthW'(depth_cnt);
    return o;
  endfunction

  // compare results first, then record new requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_cnt   = 0;
      history     = '0;
      history_len = 0;
      errors_o    = 0;
      pending_outcomes.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[12:0];
        if (pending_outcomes.size() == 0) begin
          $error("result 0x%04h arrived with no request outstanding", m_tdata_i);
          errors_o++;
        end else begin
          want = pending_outcomes.pop_front();
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors_o++;
          end
          if (got.closer != want.closer) begin
            $error("expected_closer: expected %0d, got %0d", want.closer, got.closer);
            errors_o++;
          end
          if (got.depth != want.depth) begin
            $error("nesting_depth: expected %0d, got %0d", want.depth, got.depth);
            errors_o++;
          end
          if (m_tdata_i[15:13] != 3'd0) begin
            $error("padding: expected 0, got %0d", m_tdata_i[15:13]);
            errors_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        pending_outcomes.insert(pending_outcomes.size(), scan_char(s_tdata_i, s_tlast_i));
      end
    end
    pending_o = pending_outcomes.size();
  end

endmodule

>>> tb/tb_top.sv
// testbench top: clock, reset, source text stimulus, result back-pressure and verdict
module tb_top;
  import bkbc_pkg::*;

  localparam int unsigned STACK_DEPTH  = 64;
  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] character
  logic        s_axis_tlast;   // end_of_program
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;   // [2:0] status, [5:3] expected_closer, [12:6] nesting_depth

  int unsigned error_count;
  int unsigned pending_results;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_reqs = 0;
  int unsigned holds_granted = 0;
  int unsigned stall_left = 0;
  int unsigned calm_left = 0;
  int unsigned prog_no = 0;
  bit          quiet = 1'b0;

  bracket_keyword_balance_checker_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bkbc_balance_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .errors_o   (error_count),
    .pending_o  (pending_results)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // runaway guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // idle length: mostly short, now and then long
  function automatic int unsigned gap_cycles();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // result back-pressure with random stalls, calm stretches and requested long holds
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      calm_left  = 0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (holds_granted != hold_reqs) begin
      holds_granted++;
      stall_left = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (calm_left != 0) calm_left--;
      else if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 200);
      if (calm_left == 0 && $urandom_range(0, 3) == 0) begin
        stall_left = gap_cycles() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // one request, with an optional gap before it
  task automatic send_item(input logic [7:0] ch, input logic eop);
    int unsigned gap;
    gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : gap_cycles();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= eop;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_text(input string word);
    for (int i = 0; i < word.len(); i++) send_item(word[i], 1'b0);
  endtask

  task automatic send_opener(input logic [1:0] kind);
    case (kind)
      KIND_PAREN: send_item(CH_LPAREN, 1'b0);
      KIND_SQUARE: send_item(CH_LSQ, 1'b0);
      KIND_CURLY: send_item(CH_LCURLY, 1'b0);
      default: begin
        if ($urandom_range(0, 1) != 0) send_text("begin");
        else send_text("BEGIN");
      end
    endcase
  endtask

  task automatic send_closer(input logic [1:0] kind);
    case (kind)
      KIND_PAREN: send_item(CH_RPAREN, 1'b0);
      KIND_SQUARE: send_item(CH_RSQ, 1'b0);
      KIND_CURLY: send_item(CH_RCURLY, 1'b0);
      default: begin
        if ($urandom_range(0, 1) != 0) send_text("end");
        else send_text("END");
      end
    endcase
  endtask

  // plain bytes biased toward keyword letters for near misses
  function automatic logic [7:0] filler_char();
    string letters;
    letters = "beginBEGINdD<> _x";
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return letters[$urandom_range(0, letters.len() - 1)];
  endfunction

  // one program: mostly nested well-formed text, some noise and broken closes
  task automatic random_program();
    logic [1:0]  open_kinds [$];
    logic [1:0]  k;
    int unsigned pick;
    int unsigned goal;
    bit          deep;
    deep  = ($urandom_range(0, 11) == 0) || (prog_no == 3);
    quiet = ($urandom_range(0, 4) == 0);
    if (deep) begin
      // run past the stack limit to hit overflow
      repeat (STACK_DEPTH + $urandom_range(1, 4)) begin
        k = 2'($urandom_range(0, 3));
        send_opener(k);
        if (open_kinds.size() < STACK_DEPTH) open_kinds.insert(open_kinds.size(), k);
      end
    end else begin
      goal = $urandom_range(1, 10);
      repeat ($urandom_range(8, 45)) begin
        pick = $urandom_range(0, 99);
        if (pick < 30 && open_kinds.size() < goal) begin
          k = 2'($urandom_range(0, 3));
          send_opener(k);
          open_kinds.insert(open_kinds.size(), k);
        end else if (pick < 55) begin
          if (open_kinds.size() == 0 || $urandom_range(0, 9) == 0) begin
            k = 2'($urandom_range(0, 3));
            send_closer(k);
            if (open_kinds.size() != 0 && open_kinds[$] == k) void'(open_kinds.pop_back());
          end else begin
            send_closer(open_kinds.pop_back());
          end
        end else if (pick < 62) begin
          send_item(8'($urandom_range(0, 255)), 1'b0);
        end else begin
          repeat ($urandom_range(1, 4)) send_item(filler_char(), 1'b0);
        end
      end
    end
    // usually close what is open so the verdict is balanced
    if ($urandom_range(0, 4) != 0) begin
      while (open_kinds.size() != 0) send_closer(open_kinds.pop_back());
    end
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // stimulus and verdict
  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: each opener, mismatch on curly against begin, keyword close,
    // mismatched closes, angle brackets and extreme bytes as plain, unbalanced verdicts
    send_text("([{begin}end])");
    send_item(CH_RPAREN, 1'b0);
    send_text("<>");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
    send_text("[wend");
    send_item(8'h00, 1'b1);

    while (items_sent < RANDOM_ITEMS) begin
      if (prog_no % 16 == 5) hold_reqs++;
      random_program();
      if (prog_no % 4 == 2) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (pending_results != 0) @(posedge clk_i);
      end
      prog_no++;
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
